>>> sv/towr_pkg.sv
package towr_pkg;

  // Internal cursor widths: cover COLUMNS up to 128 and ROWS up to 64.
  localparam int COL_W = 7;
  localparam int ROW_W = 6;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE_FLAGS     = 3'd0;
  localparam logic [2:0] REG_EOL_CHAR       = 3'd1;
  localparam logic [2:0] REG_ERASE_CHAR     = 3'd2;
  localparam logic [2:0] REG_KILL_CHAR      = 3'd3;
  localparam logic [2:0] REG_CELL_ATTRIBUTE = 3'd4;

  // mode_flags bit positions.
  localparam int MF_CANON    = 0;
  localparam int MF_ECHOE    = 1;
  localparam int MF_ECHOK    = 2;
  localparam int MF_CR2NL    = 3;
  localparam int MF_NL2CR    = 4;
  localparam int MF_IGNCR    = 5;

  // Up to three cursor ops per item; ch[0] runs first.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] ch;
  } op_list_t;

  typedef struct packed {
    logic [7:0] eol_byte;
    logic [7:0] erase_byte;
    logic [7:0] cell_attribute;
  } cur_cfg_t;

  typedef struct packed {
    logic        cell_write;
    logic [4:0]  row;
    logic [6:0]  column;
    logic [15:0] cell_value;
    logic        scrolled;
    logic [6:0]  cursor_x;
    logic [4:0]  cursor_y;
  } cur_res_t;

endpackage

>>> sv/towr_decode.sv
module towr_decode import towr_pkg::*; (
  input  logic [5:0] mode_flags,
  input  logic [7:0] eol_byte,
  input  logic [7:0] erase_byte,
  input  logic [7:0] kill_byte,
  input  logic [7:0] out_char,
  input  logic       output_stopped,
  output op_list_t   ops
);

  logic       pre;
  logic [7:0] c1;
  logic [7:0] c2;
  logic       fin_ok;

  always_comb begin
    pre    = 1'b0;
    c1     = out_char;
    c2     = out_char;
    fin_ok = 1'b1;
    if (mode_flags[MF_CANON]) begin
      pre = mode_flags[MF_ECHOE] && (out_char == erase_byte);
      priority if (pre) begin
        c1 = erase_byte;
      end else if (mode_flags[MF_ECHOK] && (out_char == kill_byte)) begin
        c1 = eol_byte;
      end else if ((out_char == CH_CR) && mode_flags[MF_CR2NL]) begin
        c1 = CH_NL;
      end else begin
        c1 = out_char;
      end
      c2 = ((c1 == CH_NL) && mode_flags[MF_NL2CR]) ? CH_CR : c1;
      fin_ok = !((c2 == CH_CR) && mode_flags[MF_IGNCR]) && !output_stopped;
    end

    // Echo-erase: erase, space, then the (possibly dropped) final erase.
    if (pre) begin
      ops.cnt   = fin_ok ? 2'd3 : 2'd2;
      ops.ch[0] = erase_byte;
      ops.ch[1] = CH_SPACE;
      ops.ch[2] = c2;
    end else begin
      ops.cnt   = fin_ok ? 2'd1 : 2'd0;
      ops.ch[0] = c2;
      ops.ch[1] = 8'h00;
      ops.ch[2] = 8'h00;
    end
  end

endmodule

>>> sv/towr_cursor.sv
module towr_cursor import towr_pkg::*; #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic [7:0]       ch,
  input  cur_cfg_t         cfg,
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  output logic [COL_W-1:0] col_nxt,
  output logic [ROW_W-1:0] row_nxt,
  output cur_res_t         res
);

  logic [COL_W:0] col_inc;
  logic [ROW_W:0] row_inc;
  logic           adv;
  logic           is_eol;
  logic           is_erase;

  assign col_inc  = {1'b0, col} + 1'b1;
  assign row_inc  = {1'b0, row} + 1'b1;
  assign is_eol   = (ch == cfg.eol_byte);
  assign is_erase = !is_eol && (ch == cfg.erase_byte);

  always_comb begin
    adv     = 1'b0;
    col_nxt = col;
    priority if (is_eol) begin
      col_nxt = '0;
      adv     = 1'b1;
    end else if (is_erase) begin
      col_nxt = (col != '0) ? col - 1'b1 : '0;
    end else if (col_inc >= (COL_W+1)'(COLUMNS)) begin
      col_nxt = '0;
      adv     = 1'b1;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end

    row_nxt      = row;
    res.scrolled = 1'b0;
    if (adv) begin
      if (row_inc >= (ROW_W+1)'(ROWS)) begin
        row_nxt      = ROW_W'(ROWS - 1);
        res.scrolled = 1'b1;
      end else begin
        row_nxt = row_inc[ROW_W-1:0];
      end
    end

    res.cell_write = !is_eol && !is_erase;
    res.row        = res.cell_write ? row[4:0] : 5'd0;
    res.column     = res.cell_write ? col[6:0] : 7'd0;
    res.cell_value = res.cell_write ? {cfg.cell_attribute, ch} : 16'd0;
    res.cursor_x   = col_nxt[6:0];
    res.cursor_y   = row_nxt[4:0];
  end

endmodule

>>> sv/terminal_output_cell_writer_unit.sv
// Path: an accepted item goes through the op register, then the output register, to out_valid.
// Throughput: one result per cycle while out_stall is low; an item yielding one result
//   is taken every cycle; an echo-erase item keeps the op register until its ops fire.
// An item that yields no result is absorbed without using the cursor stage.
// Reset (rst_n low, synchronous): cursor to 0,0, registers to defaults, no item in flight.
module terminal_output_cell_writer_unit import towr_pkg::*; #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_out_char,
  input  logic        in_output_stopped,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_cell_write,
  output logic [4:0]  out_row,
  output logic [6:0]  out_column,
  output logic [15:0] out_cell_value,
  output logic        out_scrolled,
  output logic [6:0]  out_cursor_x,
  output logic [4:0]  out_cursor_y,
  output logic        out_last_of_run
);

  // Configuration registers; the port never pushes back.
  logic [5:0] mode_flags_r;
  logic [7:0] eol_byte_r;
  logic [7:0] erase_byte_r;
  logic [7:0] kill_byte_r;
  logic [7:0] cell_attribute_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_flags_r     <= 6'd39;
      eol_byte_r       <= 8'd10;
      erase_byte_r     <= 8'd8;
      kill_byte_r      <= 8'd21;
      cell_attribute_r <= 8'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE_FLAGS:     mode_flags_r     <= cfg_data[5:0];
        REG_EOL_CHAR:       eol_byte_r       <= cfg_data;
        REG_ERASE_CHAR:     erase_byte_r     <= cfg_data;
        REG_KILL_CHAR:      kill_byte_r      <= cfg_data;
        REG_CELL_ATTRIBUTE: cell_attribute_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Translation of the incoming byte into a list of cursor ops (canonical mode; else one op).
  op_list_t dec_ops;

  towr_decode u_decode (
    .mode_flags     (mode_flags_r),
    .eol_byte       (eol_byte_r),
    .erase_byte     (erase_byte_r),
    .kill_byte      (kill_byte_r),
    .out_char       (in_out_char),
    .output_stopped (in_output_stopped),
    .ops            (dec_ops)
  );

  // Op register: remaining ops of the current item, head in ch[0].
  logic [1:0]      a_cnt_r, a_cnt_nxt;
  logic [2:0][7:0] a_ch_r, a_ch_nxt;

  // Output register and cursor state.
  logic             o_valid_r, o_valid_nxt;
  cur_res_t         o_res_r;
  logic             o_last_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  cur_res_t         cur_res;
  cur_cfg_t         cur_cfg;

  logic fire;    // head op executes into the output register this cycle
  logic accept;  // input item taken this cycle

  assign fire     = (a_cnt_r != 2'd0) && (!o_valid_r || !out_stall);
  // Op register frees when empty or when its last op fires now.
  assign in_stall = (a_cnt_r != 2'd0) && !((a_cnt_r == 2'd1) && fire);
  assign accept   = in_valid && !in_stall;

  assign cur_cfg.eol_byte       = eol_byte_r;
  assign cur_cfg.erase_byte     = erase_byte_r;
  assign cur_cfg.cell_attribute = cell_attribute_r;

  towr_cursor #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_cursor (
    .ch      (a_ch_r[0]),
    .cfg     (cur_cfg),
    .col     (col_r),
    .row     (row_r),
    .col_nxt (col_nxt),
    .row_nxt (row_nxt),
    .res     (cur_res)
  );

  always_comb begin
    a_cnt_nxt = a_cnt_r;
    a_ch_nxt  = a_ch_r;
    if (accept) begin
      a_cnt_nxt = dec_ops.cnt;
      a_ch_nxt  = dec_ops.ch;
    end else if (fire) begin
      a_cnt_nxt = a_cnt_r - 2'd1;
      a_ch_nxt  = {8'h00, a_ch_r[2], a_ch_r[1]};
    end
  end

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (fire) begin
      o_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r   <= 2'd0;
      o_valid_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      a_cnt_r   <= a_cnt_nxt;
      o_valid_r <= o_valid_nxt;
      if (fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    a_ch_r <= a_ch_nxt;
    if (fire) begin
      o_res_r  <= cur_res;
      o_last_r <= (a_cnt_r == 2'd1);
    end
  end

  assign out_valid       = o_valid_r;
  assign out_cell_write  = o_res_r.cell_write;
  assign out_row         = o_res_r.row;
  assign out_column      = o_res_r.column;
  assign out_cell_value  = o_res_r.cell_value;
  assign out_scrolled    = o_res_r.scrolled;
  assign out_cursor_x    = o_res_r.cursor_x;
  assign out_cursor_y    = o_res_r.cursor_y;
  assign out_last_of_run = o_last_r;

endmodule
